FILE: design/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and constants of the elastic disc collision unit.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int unsigned VelW    = 20;
  localparam int unsigned PosW    = 20;
  localparam int unsigned MassW   = 14;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [RadiusW-1:0] RadiusReset = 16'd5120;

  // Register index of the disc radius; it is the only register.
  localparam logic RegRadius = 1'b0;

  // Quotient widths of the projection and the mass weighting dividers.
  localparam int unsigned QtW = 22;
  localparam int unsigned QcW = 23;

  typedef struct packed {
    logic                    valid;
    logic signed [VelW-1:0]  v1x;
    logic signed [VelW-1:0]  v1y;
    logic signed [VelW-1:0]  v2x;
    logic signed [VelW-1:0]  v2y;
    logic [MassW-1:0]        m1;
    logic [MassW-1:0]        m2;
    logic [MassW:0]          msum;
    logic                    contact;
    logic                    coinc;
    logic                    doit;
  } side_t;

  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [VelW+5:0] v);
    logic signed [VelW+5:0] hi;
    logic signed [VelW+5:0] lo;
    hi = (VelW+6)'(2 ** (VelW-1) - 1);
    lo = -(VelW+6)'(2 ** (VelW-1));
    if (v > hi) begin
      sat_vel = hi[VelW-1:0];
    end else if (v < lo) begin
      sat_vel = lo[VelW-1:0];
    end else begin
      sat_vel = v[VelW-1:0];
    end
  endfunction

endpackage

FILE: design/edc_rdiv_pipe.sv
// ----------------------------------------------------------------------------
// edc_rdiv_pipe
// Pipelined signed divider, one quotient bit per stage, rounding to nearest
// with ties away from zero. It takes one transfer per cycle.
// ----------------------------------------------------------------------------
module edc_rdiv_pipe #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 22
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic signed [QW:0]   quo
);

  localparam int unsigned RW = NW + 1;
  localparam int unsigned SW = DW + 1 + QW;
  localparam int unsigned W  = (RW > SW) ? RW : SW;

  logic [W-1:0]  rem_r [QW+1];
  logic [DW:0]   d2_r  [QW+1];
  logic          neg_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [W-1:0]  trial [1:QW];
  logic          ge    [1:QW];
  logic [NW-1:0] mag;
  logic signed [QW:0] quo_r;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_comb begin
    for (int j = 1; j <= QW; j++) begin
      trial[j] = W'(d2_r[j-1]) << (QW - j);
      ge[j]    = rem_r[j-1] >= trial[j];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= W'({mag, 1'b0}) + W'(den);
    d2_r[0]  <= {den, 1'b0};
    neg_r[0] <= num[NW-1];
    q_r[0]   <= '0;
    for (int j = 1; j <= QW; j++) begin
      rem_r[j] <= ge[j] ? rem_r[j-1] - trial[j] : rem_r[j-1];
      d2_r[j]  <= d2_r[j-1];
      neg_r[j] <= neg_r[j-1];
      q_r[j]   <= q_r[j-1] | (QW'(ge[j]) << (QW - j));
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
  end

  assign quo = quo_r;

endmodule

FILE: design/elastic_disc_collision_unit.sv
// ----------------------------------------------------------------------------
// elastic_disc_collision_unit
// Elastic collision response for one pair of equal-radius discs.
//
// A pair is taken on a rising edge where start is high and busy is low; busy
// is always low, so a new pair may be sent in every cycle. Each pair yields
// exactly one result, shown for one cycle with out_valid. The receiver cannot
// stall, so the pipeline advances in every cycle. The pipeline is built
// around the two bit-per-stage dividers: 24 stages for the projection onto
// the centre line and 25 for the mass weighting, plus seven stages of
// multiply and add around them. Throughput is one pair per cycle. The disc
// radius must be written through the configuration port only while no pair
// is in flight; the block does not enforce this. Reset empties the pipeline
// and sets the radius to 5120. Pairs in contact get the elastic rule;
// others, pairs with coincident centres and pairs of zero total mass pass
// their velocities through. All velocities are saturated to the 20-bit range.
// ----------------------------------------------------------------------------
module elastic_disc_collision_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [edc_pkg::PosW-1:0]    in_first_pos_x,
  input  logic [edc_pkg::PosW-1:0]    in_first_pos_y,
  input  logic [edc_pkg::PosW-1:0]    in_second_pos_x,
  input  logic [edc_pkg::PosW-1:0]    in_second_pos_y,
  input  logic signed [edc_pkg::VelW-1:0] in_first_vel_x,
  input  logic signed [edc_pkg::VelW-1:0] in_first_vel_y,
  input  logic signed [edc_pkg::VelW-1:0] in_second_vel_x,
  input  logic signed [edc_pkg::VelW-1:0] in_second_vel_y,
  input  logic [edc_pkg::MassW-1:0]   in_first_mass,
  input  logic [edc_pkg::MassW-1:0]   in_second_mass,
  output logic                        out_valid,
  output logic signed [edc_pkg::VelW-1:0] out_new_first_vel_x,
  output logic signed [edc_pkg::VelW-1:0] out_new_first_vel_y,
  output logic signed [edc_pkg::VelW-1:0] out_new_second_vel_x,
  output logic signed [edc_pkg::VelW-1:0] out_new_second_vel_y,
  output logic                        out_contact,
  output logic                        out_coincident,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [edc_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [edc_pkg::DataW-1:0]   cfg_pwdata,
  output logic [edc_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned NtW = 58;
  localparam int unsigned DtW = 34;
  localparam int unsigned NcW = 39;
  localparam int unsigned DcW = edc_pkg::MassW + 1;
  localparam int unsigned LT  = edc_pkg::QtW + 2;
  localparam int unsigned LC  = edc_pkg::QcW + 2;

  logic [edc_pkg::RadiusW-1:0] radius_r;
  logic                        reg_sel;

  assign busy       = 1'b0;
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[edc_pkg::AddrW-1] == edc_pkg::RegRadius;
  assign cfg_prdata = reg_sel ? edc_pkg::DataW'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= edc_pkg::RadiusReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      radius_r <= cfg_pwdata[edc_pkg::RadiusW-1:0];
    end
  end

  // Stage 1: differences.
  edc_pkg::side_t      side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  edc_pkg::side_t      side1_nxt;
  logic signed [20:0]  dx1_r, dy1_r, dvx1_r, dvy1_r;
  logic [16:0]         reach1_r;

  always_comb begin
    side1_nxt         = '0;
    side1_nxt.valid   = start;
    side1_nxt.v1x     = in_first_vel_x;
    side1_nxt.v1y     = in_first_vel_y;
    side1_nxt.v2x     = in_second_vel_x;
    side1_nxt.v2y     = in_second_vel_y;
    side1_nxt.m1      = in_first_mass;
    side1_nxt.m2      = in_second_mass;
    side1_nxt.msum    = {1'b0, in_first_mass} + {1'b0, in_second_mass};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
    end else begin
      side1_r <= side1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r    <= $signed({1'b0, in_first_pos_x}) - $signed({1'b0, in_second_pos_x});
    dy1_r    <= $signed({1'b0, in_first_pos_y}) - $signed({1'b0, in_second_pos_y});
    dvx1_r   <= $signed({in_first_vel_x[19], in_first_vel_x})
              - $signed({in_second_vel_x[19], in_second_vel_x});
    dvy1_r   <= $signed({in_first_vel_y[19], in_first_vel_y})
              - $signed({in_second_vel_y[19], in_second_vel_y});
    reach1_r <= {radius_r, 1'b0};
  end

  // Stage 2: squares and dot product terms.
  logic signed [41:0] dxx, dyy;
  logic [40:0]        dxx2_r, dyy2_r;
  logic signed [38:0] px2_r, py2_r;
  logic [33:0]        rsq2_r;
  logic signed [17:0] dxs2_r, dys2_r;

  assign dxx = dx1_r * dx1_r;
  assign dyy = dy1_r * dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r <= '0;
    end else begin
      side2_r <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    dxx2_r <= dxx[40:0];
    dyy2_r <= dyy[40:0];
    px2_r  <= dvx1_r * $signed(dx1_r[17:0]);
    py2_r  <= dvy1_r * $signed(dy1_r[17:0]);
    rsq2_r <= reach1_r * reach1_r;
    dxs2_r <= dx1_r[17:0];
    dys2_r <= dy1_r[17:0];
  end

  // Stage 3: sums.
  logic [41:0]        dsq3_r;
  logic signed [39:0] dot3_r;
  logic [33:0]        rsq3_r;
  logic signed [17:0] dxs3_r, dys3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r <= '0;
    end else begin
      side3_r <= side2_r;
    end
  end

  always_ff @(posedge clk) begin
    dsq3_r <= {1'b0, dxx2_r} + {1'b0, dyy2_r};
    dot3_r <= 40'(px2_r) + 40'(py2_r);
    rsq3_r <= rsq2_r;
    dxs3_r <= dxs2_r;
    dys3_r <= dys2_r;
  end

  // Stage 4: contact test and partial products of the numerators.
  logic               contact4, coinc4;
  edc_pkg::side_t     side4_nxt;
  logic signed [38:0] plx4_r, ply4_r;
  logic signed [37:0] phx4_r, phy4_r;
  logic [33:0]        dsq4_r;
  logic signed [20:0] dot_lo;
  logic signed [19:0] dot_hi;

  assign contact4 = dsq3_r <= 42'(rsq3_r);
  assign coinc4   = dsq3_r == '0;
  assign dot_lo   = $signed({1'b0, dot3_r[19:0]});
  assign dot_hi   = dot3_r[39:20];

  always_comb begin
    side4_nxt         = side3_r;
    side4_nxt.contact = contact4;
    side4_nxt.coinc   = coinc4;
    side4_nxt.doit    = contact4 && !coinc4 && (side3_r.msum != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r <= '0;
    end else begin
      side4_r <= side4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plx4_r <= dot_lo * dxs3_r;
    ply4_r <= dot_lo * dys3_r;
    phx4_r <= dot_hi * dxs3_r;
    phy4_r <= dot_hi * dys3_r;
    dsq4_r <= dsq3_r[33:0];
  end

  // Stage 5: numerators.
  logic signed [NtW-1:0] nx5_r, ny5_r;
  logic [DtW-1:0]        dsq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r <= '0;
    end else begin
      side5_r <= side4_r;
    end
  end

  always_ff @(posedge clk) begin
    nx5_r  <= (NtW'(phx4_r) <<< 20) + NtW'(plx4_r);
    ny5_r  <= (NtW'(phy4_r) <<< 20) + NtW'(ply4_r);
    dsq5_r <= dsq4_r;
  end

  // Projection onto the centre line.
  logic signed [edc_pkg::QtW:0] tx, ty;

  edc_rdiv_pipe #(.NW(NtW), .DW(DtW), .QW(edc_pkg::QtW)) u_div_tx (
    .clk (clk), .num (nx5_r), .den (dsq5_r), .quo (tx)
  );

  edc_rdiv_pipe #(.NW(NtW), .DW(DtW), .QW(edc_pkg::QtW)) u_div_ty (
    .clk (clk), .num (ny5_r), .den (dsq5_r), .quo (ty)
  );

  edc_pkg::side_t sdt_r [LT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LT; i++) begin
        sdt_r[i] <= '0;
      end
    end else begin
      sdt_r[0] <= side5_r;
      for (int i = 1; i < LT; i++) begin
        sdt_r[i] <= sdt_r[i-1];
      end
    end
  end

  // Stage 6: mass weighting numerators.
  logic signed [15:0]    w1, w2;
  logic signed [NcW-1:0] c1x6_r, c1y6_r, c2x6_r, c2y6_r;

  assign w1 = $signed({1'b0, sdt_r[LT-1].m1, 1'b0});
  assign w2 = $signed({1'b0, sdt_r[LT-1].m2, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side6_r <= '0;
    end else begin
      side6_r <= sdt_r[LT-1];
    end
  end

  always_ff @(posedge clk) begin
    c1x6_r <= tx * w2;
    c1y6_r <= ty * w2;
    c2x6_r <= tx * w1;
    c2y6_r <= ty * w1;
  end

  logic signed [edc_pkg::QcW:0] c1x, c1y, c2x, c2y;

  edc_rdiv_pipe #(.NW(NcW), .DW(DcW), .QW(edc_pkg::QcW)) u_div_c1x (
    .clk (clk), .num (c1x6_r), .den (side6_r.msum), .quo (c1x)
  );

  edc_rdiv_pipe #(.NW(NcW), .DW(DcW), .QW(edc_pkg::QcW)) u_div_c1y (
    .clk (clk), .num (c1y6_r), .den (side6_r.msum), .quo (c1y)
  );

  edc_rdiv_pipe #(.NW(NcW), .DW(DcW), .QW(edc_pkg::QcW)) u_div_c2x (
    .clk (clk), .num (c2x6_r), .den (side6_r.msum), .quo (c2x)
  );

  edc_rdiv_pipe #(.NW(NcW), .DW(DcW), .QW(edc_pkg::QcW)) u_div_c2y (
    .clk (clk), .num (c2y6_r), .den (side6_r.msum), .quo (c2y)
  );

  edc_pkg::side_t sdc_r [LC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LC; i++) begin
        sdc_r[i] <= '0;
      end
    end else begin
      sdc_r[0] <= side6_r;
      for (int i = 1; i < LC; i++) begin
        sdc_r[i] <= sdc_r[i-1];
      end
    end
  end

  // Stage 7: velocity update and saturation.
  edc_pkg::side_t    sf;
  logic signed [25:0] n1x, n1y, n2x, n2y;
  logic               valid_r;
  logic signed [edc_pkg::VelW-1:0] o1x_r, o1y_r, o2x_r, o2y_r;
  logic               contact_r, coinc_r;

  assign sf  = sdc_r[LC-1];
  assign n1x = 26'(sf.v1x) - 26'(c1x);
  assign n1y = 26'(sf.v1y) - 26'(c1y);
  assign n2x = 26'(sf.v2x) + 26'(c2x);
  assign n2y = 26'(sf.v2y) + 26'(c2y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sf.valid;
    end
  end

  always_ff @(posedge clk) begin
    o1x_r     <= sf.doit ? edc_pkg::sat_vel(n1x) : sf.v1x;
    o1y_r     <= sf.doit ? edc_pkg::sat_vel(n1y) : sf.v1y;
    o2x_r     <= sf.doit ? edc_pkg::sat_vel(n2x) : sf.v2x;
    o2y_r     <= sf.doit ? edc_pkg::sat_vel(n2y) : sf.v2y;
    contact_r <= sf.contact;
    coinc_r   <= sf.coinc;
  end

  assign out_valid            = valid_r;
  assign out_new_first_vel_x  = o1x_r;
  assign out_new_first_vel_y  = o1y_r;
  assign out_new_second_vel_x = o2x_r;
  assign out_new_second_vel_y = o2y_r;
  assign out_contact          = contact_r;
  assign out_coincident       = coinc_r;

endmodule
